[hdl/cstr_pkg.sv]
// Shared types, constants and tables of the cubic stiffness rotation block.
package cstr_pkg;

  localparam int unsigned LIMB_W     = 32;
  localparam int unsigned RESULT_W   = 40;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned TERM_IW    = 5;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [RESULT_W-1:0] SAT_POS = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic [RESULT_W-1:0] SAT_NEG = {1'b1, {(RESULT_W-1){1'b0}}};

  localparam logic [IDX_W-1:0] VOIGT_FIRST_IDX = 3'd0;
  localparam logic [IDX_W-1:0] VOIGT_LAST_IDX  = 3'd5;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ROT_ROW0 = 2'd0;
  localparam cfg_idx_t REG_ROT_ROW1 = 2'd1;
  localparam cfg_idx_t REG_ROT_ROW2 = 2'd2;

  // Tensor axis 0..2
  typedef logic [1:0] axis_t;

  // Modulus selector of one tensor term
  typedef logic [1:0] msel_t;
  localparam msel_t SEL_C11 = 2'd0;
  localparam msel_t SEL_C12 = 2'd1;
  localparam msel_t SEL_C44 = 2'd2;

  typedef logic [TERM_IW-1:0] term_idx_t;
  localparam term_idx_t FIRST_TERM = 5'd0;
  localparam term_idx_t LAST_TERM  = 5'd20;

  typedef struct packed {
    axis_t i;
    axis_t j;
    axis_t k;
    axis_t l;
    msel_t sel;
  } term_t;

  typedef struct packed {
    logic init_acc;
    logic load_term;
    logic step;
    logic last_pass;
    logic neg;
  } mac_ctrl_t;

  // Accumulator limbs: room for the full signed sum and for the rounded result
  function automatic int unsigned acc_limbs(input int unsigned frac_bits,
                                            input int unsigned mod_w);
    int unsigned need_a;
    int unsigned need_b;
    need_a = mod_w + 4*(frac_bits + 2) + 1;
    need_b = 4*frac_bits + RESULT_W + 1;
    return (((need_a > need_b) ? need_a : need_b) + LIMB_W - 1) / LIMB_W;
  endfunction

  // Width of a limb index into the accumulator
  function automatic int unsigned limb_idx_w(input int unsigned frac_bits,
                                             input int unsigned mod_w);
    return unsigned'($clog2(acc_limbs(frac_bits, mod_w)));
  endfunction

  // First tensor axis of a Voigt index
  function automatic axis_t voigt_first(input logic [IDX_W-1:0] v);
    axis_t a;
    unique case (v)
      3'd0:    a = 2'd0;
      3'd1:    a = 2'd1;
      3'd2:    a = 2'd2;
      3'd3:    a = 2'd1;
      default: a = 2'd0;
    endcase
    return a;
  endfunction

  // Second tensor axis of a Voigt index
  function automatic axis_t voigt_second(input logic [IDX_W-1:0] v);
    axis_t a;
    unique case (v)
      3'd0:    a = 2'd0;
      3'd1:    a = 2'd1;
      3'd2:    a = 2'd2;
      3'd3:    a = 2'd2;
      3'd4:    a = 2'd2;
      3'd5:    a = 2'd1;
      default: a = 2'd0;
    endcase
    return a;
  endfunction

  // Non-zero entries of the cubic tensor: normal-normal couplings, then shear pairs
  function automatic term_t term_at(input term_idx_t n);
    term_t t;
    unique case (n)
      5'd0:    t = '{2'd0, 2'd0, 2'd0, 2'd0, SEL_C11};
      5'd1:    t = '{2'd0, 2'd0, 2'd1, 2'd1, SEL_C12};
      5'd2:    t = '{2'd0, 2'd0, 2'd2, 2'd2, SEL_C12};
      5'd3:    t = '{2'd1, 2'd1, 2'd0, 2'd0, SEL_C12};
      5'd4:    t = '{2'd1, 2'd1, 2'd1, 2'd1, SEL_C11};
      5'd5:    t = '{2'd1, 2'd1, 2'd2, 2'd2, SEL_C12};
      5'd6:    t = '{2'd2, 2'd2, 2'd0, 2'd0, SEL_C12};
      5'd7:    t = '{2'd2, 2'd2, 2'd1, 2'd1, SEL_C12};
      5'd8:    t = '{2'd2, 2'd2, 2'd2, 2'd2, SEL_C11};
      5'd9:    t = '{2'd1, 2'd2, 2'd1, 2'd2, SEL_C44};
      5'd10:   t = '{2'd1, 2'd2, 2'd2, 2'd1, SEL_C44};
      5'd11:   t = '{2'd2, 2'd1, 2'd1, 2'd2, SEL_C44};
      5'd12:   t = '{2'd2, 2'd1, 2'd2, 2'd1, SEL_C44};
      5'd13:   t = '{2'd0, 2'd2, 2'd0, 2'd2, SEL_C44};
      5'd14:   t = '{2'd0, 2'd2, 2'd2, 2'd0, SEL_C44};
      5'd15:   t = '{2'd2, 2'd0, 2'd0, 2'd2, SEL_C44};
      5'd16:   t = '{2'd2, 2'd0, 2'd2, 2'd0, SEL_C44};
      5'd17:   t = '{2'd0, 2'd1, 2'd0, 2'd1, SEL_C44};
      5'd18:   t = '{2'd0, 2'd1, 2'd1, 2'd0, SEL_C44};
      5'd19:   t = '{2'd1, 2'd0, 2'd0, 2'd1, SEL_C44};
      5'd20:   t = '{2'd1, 2'd0, 2'd1, 2'd0, SEL_C44};
      default: t = '{2'd0, 2'd0, 2'd0, 2'd0, SEL_C11};
    endcase
    return t;
  endfunction

endpackage

[hdl/cubic_stiffness_rotation.sv]
// Top level: rotates the cubic stiffness tensor and streams the 36 Voigt entries.
//
// One input transaction carries c11, c12 and c44 and yields 36 output transactions,
// Voigt row-major, the last one flagged with tlast. Each entry is the exact sum of the
// 21 non-zero rotated tensor terms, rounded to nearest (ties up) and saturated to 40
// bits. All arithmetic runs through one 32-by-18 limb multiplier and one 32-bit adder
// with a carry held between limbs, stepping one 32-bit limb per cycle. An entry is an
// initialising step, then for each of the 21 terms a load step and factor passes over
// L0, L1, L2 and NL limbs, where L0..L2 are the limb counts of the partial products and
// NL the accumulator limbs, then an emit step that holds while the output is stalled.
// The input is not ready until the last entry has been handed to the output register.
// Rotation rows are to be written through the configuration channel only while the block
// is idle; the block itself does not enforce this. They reset to the identity matrix.
module cubic_stiffness_rotation #(
  parameter int unsigned ROT_FRAC_BITS = 16,
  parameter int unsigned MODULUS_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // tdata: modulus_c11, modulus_c12, modulus_c44
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((3*MODULUS_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // tdata: voigt_row[2:0], voigt_col[5:3], stiffness_value[45:6], zero fill
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [cstr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  cstr_pkg::cfg_idx_t                     cfg_index_i,
  input  logic [((3*(ROT_FRAC_BITS+2) < 64) ? 3*(ROT_FRAC_BITS+2) : 64)-1:0] cfg_data_i
);
  import cstr_pkg::*;

  localparam int unsigned EW      = ROT_FRAC_BITS + 2;
  localparam int unsigned RW3     = 3 * EW;
  localparam int unsigned REG_W   = (RW3 < 64) ? RW3 : 64;
  localparam int unsigned NEED_A  = MODULUS_WIDTH + 4*EW + 1;
  localparam int unsigned NEED_B  = 4*ROT_FRAC_BITS + RESULT_W + 1;
  localparam int unsigned NL      = ((NEED_A > NEED_B ? NEED_A : NEED_B) + LIMB_W - 1) / LIMB_W;
  localparam int unsigned LIMB_IW = $clog2(NL);
  // identity rows: one at the diagonal entry, truncated to the register
  localparam logic [REG_W-1:0] ID_ROW0 = REG_W'({{(RW3-1){1'b0}}, 1'b1} << (ROT_FRAC_BITS));
  localparam logic [REG_W-1:0] ID_ROW1 = REG_W'({{(RW3-1){1'b0}}, 1'b1} << (ROT_FRAC_BITS + EW));
  localparam logic [REG_W-1:0] ID_ROW2 =
    REG_W'({{(RW3-1){1'b0}}, 1'b1} << (ROT_FRAC_BITS + 2*EW));

  logic [REG_W-1:0]     rot0_q, rot1_q, rot2_q;
  mac_ctrl_t            mac_ctrl;
  logic [LIMB_IW-1:0]   limb;
  logic [EW-1:0]        factor;
  logic [MODULUS_WIDTH-1:0] load_mag;
  logic [RESULT_W-1:0]  value;
  logic                 out_free, out_load, out_last;
  logic [IDX_W-1:0]     out_row, out_col;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                 out_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot0_q <= ID_ROW0;
      rot1_q <= ID_ROW1;
      rot2_q <= ID_ROW2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROT_ROW0: rot0_q <= cfg_data_i;
        REG_ROT_ROW1: rot1_q <= cfg_data_i;
        REG_ROT_ROW2: rot2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cstr_seq #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS),
    .MODULUS_WIDTH (MODULUS_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[3*MODULUS_WIDTH-1:0]),
    .rot0_i     (rot0_q),
    .rot1_i     (rot1_q),
    .rot2_i     (rot2_q),
    .ctrl_o     (mac_ctrl),
    .limb_o     (limb),
    .factor_o   (factor),
    .load_mag_o (load_mag),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .out_last_o (out_last)
  );

  cstr_mac #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS),
    .MODULUS_WIDTH (MODULUS_WIDTH)
  ) u_mac (
    .clk_i      (clk_i),
    .ctrl_i     (mac_ctrl),
    .limb_i     (limb),
    .factor_i   (factor),
    .load_mag_i (load_mag),
    .value_o    (value)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OUT_DATA_W'({value, out_col, out_row});
      out_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[hdl/cstr_mac.sv]
// Limb-serial multiply-accumulate unit with the wide accumulator and final rounding.
module cstr_mac #(
  parameter int unsigned ROT_FRAC_BITS = 16,
  parameter int unsigned MODULUS_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  cstr_pkg::mac_ctrl_t                    ctrl_i,
  input  logic [cstr_pkg::limb_idx_w(ROT_FRAC_BITS, MODULUS_WIDTH)-1:0] limb_i,
  input  logic [ROT_FRAC_BITS+1:0]               factor_i,
  input  logic [MODULUS_WIDTH-1:0]               load_mag_i,
  output logic [cstr_pkg::RESULT_W-1:0]          value_o
);
  import cstr_pkg::*;

  localparam int unsigned EW      = ROT_FRAC_BITS + 2;
  localparam int unsigned NEED_A  = MODULUS_WIDTH + 4*EW + 1;
  localparam int unsigned NEED_B  = 4*ROT_FRAC_BITS + RESULT_W + 1;
  localparam int unsigned NL      = ((NEED_A > NEED_B ? NEED_A : NEED_B) + LIMB_W - 1) / LIMB_W;
  localparam int unsigned ACC_W   = NL * LIMB_W;
  localparam int unsigned SHIFT   = 4 * ROT_FRAC_BITS;
  localparam int unsigned HI_W    = ACC_W - SHIFT;
  // Accumulator starts at one half unit so that the final shift rounds to nearest
  localparam logic [ACC_W-1:0] ACC_INIT = ACC_W'(1) << (SHIFT - 1);

  logic [LIMB_W-1:0]   x_q   [NL];
  logic [LIMB_W-1:0]   acc_q [NL];
  logic [LIMB_W-1:0]   mcarry_q;
  logic                acarry_q;
  logic                neg_q;

  logic [2*LIMB_W-1:0] prod;
  logic [LIMB_W:0]     sum;
  logic [ACC_W-1:0]    mag_ext;
  logic [ACC_W-1:0]    acc_flat;
  logic [HI_W-1:0]     hi;
  logic                fits;

  always_comb begin
    prod = (2*LIMB_W)'(x_q[limb_i]) * (2*LIMB_W)'(factor_i) + (2*LIMB_W)'(mcarry_q);
    sum  = {1'b0, acc_q[limb_i]} + {1'b0, prod[LIMB_W-1:0] ^ {LIMB_W{neg_q}}}
           + (LIMB_W+1)'(acarry_q);
    mag_ext = ACC_W'(load_mag_i);
    for (int k = 0; k < NL; k++) begin
      acc_flat[k*LIMB_W +: LIMB_W] = acc_q[k];
    end
    hi   = acc_flat[ACC_W-1 -: HI_W];
    fits = (&hi[HI_W-1:RESULT_W-1]) | ~(|hi[HI_W-1:RESULT_W-1]);
    if (fits) begin
      value_o = hi[RESULT_W-1:0];
    end else begin
      value_o = hi[HI_W-1] ? SAT_NEG : SAT_POS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.init_acc) begin
      for (int k = 0; k < NL; k++) begin
        acc_q[k] <= ACC_INIT[k*LIMB_W +: LIMB_W];
      end
    end
    if (ctrl_i.load_term) begin
      for (int k = 0; k < NL; k++) begin
        x_q[k] <= mag_ext[k*LIMB_W +: LIMB_W];
      end
      mcarry_q <= '0;
      acarry_q <= ctrl_i.neg;
      neg_q    <= ctrl_i.neg;
    end else if (ctrl_i.step) begin
      mcarry_q <= prod[2*LIMB_W-1:LIMB_W];
      if (ctrl_i.last_pass) begin
        // add the finished product limb, negated for a negative term via invert and carry-in
        acc_q[limb_i] <= sum[LIMB_W-1:0];
        acarry_q      <= sum[LIMB_W];
      end else begin
        x_q[limb_i] <= prod[LIMB_W-1:0];
      end
    end
  end

endmodule

[hdl/cstr_seq.sv]
// Sequencer: walks entries, tensor terms, factor passes and limbs for the shared unit.
module cstr_seq #(
  parameter int unsigned ROT_FRAC_BITS = 16,
  parameter int unsigned MODULUS_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [3*MODULUS_WIDTH-1:0]             in_data_i,
  input  logic [((3*(ROT_FRAC_BITS+2) < 64) ? 3*(ROT_FRAC_BITS+2) : 64)-1:0] rot0_i,
  input  logic [((3*(ROT_FRAC_BITS+2) < 64) ? 3*(ROT_FRAC_BITS+2) : 64)-1:0] rot1_i,
  input  logic [((3*(ROT_FRAC_BITS+2) < 64) ? 3*(ROT_FRAC_BITS+2) : 64)-1:0] rot2_i,
  output cstr_pkg::mac_ctrl_t                    ctrl_o,
  output logic [cstr_pkg::limb_idx_w(ROT_FRAC_BITS, MODULUS_WIDTH)-1:0] limb_o,
  output logic [ROT_FRAC_BITS+1:0]               factor_o,
  output logic [MODULUS_WIDTH-1:0]               load_mag_o,
  input  logic                                   out_free_i,
  output logic                                   out_load_o,
  output logic [cstr_pkg::IDX_W-1:0]             out_row_o,
  output logic [cstr_pkg::IDX_W-1:0]             out_col_o,
  output logic                                   out_last_o
);
  import cstr_pkg::*;

  localparam int unsigned EW      = ROT_FRAC_BITS + 2;
  localparam int unsigned RW3     = 3 * EW;
  localparam int unsigned REG_W   = (RW3 < 64) ? RW3 : 64;
  localparam int unsigned MW      = MODULUS_WIDTH;
  localparam int unsigned NEED_A  = MW + 4*EW + 1;
  localparam int unsigned NEED_B  = 4*ROT_FRAC_BITS + RESULT_W + 1;
  localparam int unsigned NL      = ((NEED_A > NEED_B ? NEED_A : NEED_B) + LIMB_W - 1) / LIMB_W;
  localparam int unsigned LIMB_IW = $clog2(NL);
  // limbs written by each of the first three factor passes
  localparam int unsigned L0      = (MW + 1*EW + LIMB_W - 1) / LIMB_W;
  localparam int unsigned L1      = (MW + 2*EW + LIMB_W - 1) / LIMB_W;
  localparam int unsigned L2      = (MW + 3*EW + LIMB_W - 1) / LIMB_W;
  localparam logic [1:0]  PASS_FIRST = 2'd0;
  localparam logic [1:0]  PASS_LAST  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ENTRY = 5'b00010,
    S_LOAD  = 5'b00100,
    S_MUL   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   r_q, r_d, c_q, c_d;
  term_idx_t          n_q, n_d;
  logic [1:0]         pass_q, pass_d;
  logic [LIMB_IW-1:0] limb_q, limb_d, limb_last;
  logic               take_in;

  logic [MW-1:0]      mag_q  [3];
  logic               mneg_q [3];
  logic [MW-1:0]      in_mag [3];
  logic               in_neg [3];

  term_t              term;
  logic [EW-1:0]      ent_raw [4];
  logic [EW-1:0]      cur_ent;
  logic               term_neg;
  logic               mod_neg;

  function automatic logic [EW-1:0] pick_entry(input logic [REG_W-1:0] row0,
                                               input logic [REG_W-1:0] row1,
                                               input logic [REG_W-1:0] row2,
                                               input axis_t r, input axis_t c);
    logic [REG_W-1:0] row;
    logic [RW3-1:0]   ext;
    logic [EW-1:0]    e;
    unique case (r)
      2'd0:    row = row0;
      2'd1:    row = row1;
      default: row = row2;
    endcase
    // bits past the register read as zero
    ext = RW3'(row);
    unique case (c)
      2'd0:    e = ext[EW-1:0];
      2'd1:    e = ext[2*EW-1:EW];
      default: e = ext[3*EW-1:2*EW];
    endcase
    return e;
  endfunction

  always_comb begin
    for (int q = 0; q < 3; q++) begin
      in_neg[q] = in_data_i[q*MW + MW - 1];
      in_mag[q] = in_neg[q] ? (~in_data_i[q*MW +: MW]) + 1'b1 : in_data_i[q*MW +: MW];
    end
  end

  always_comb begin
    term = term_at(n_q);
    ent_raw[0] = pick_entry(rot0_i, rot1_i, rot2_i, voigt_first(r_q),  term.i);
    ent_raw[1] = pick_entry(rot0_i, rot1_i, rot2_i, voigt_second(r_q), term.j);
    ent_raw[2] = pick_entry(rot0_i, rot1_i, rot2_i, voigt_first(c_q),  term.k);
    ent_raw[3] = pick_entry(rot0_i, rot1_i, rot2_i, voigt_second(c_q), term.l);
    cur_ent  = ent_raw[pass_q];
    factor_o = cur_ent[EW-1] ? (~cur_ent) + 1'b1 : cur_ent;
    unique case (term.sel)
      SEL_C11: begin
        load_mag_o = mag_q[0];
        mod_neg    = mneg_q[0];
      end
      SEL_C12: begin
        load_mag_o = mag_q[1];
        mod_neg    = mneg_q[1];
      end
      default: begin
        load_mag_o = mag_q[2];
        mod_neg    = mneg_q[2];
      end
    endcase
    term_neg = mod_neg ^ ent_raw[0][EW-1] ^ ent_raw[1][EW-1]
               ^ ent_raw[2][EW-1] ^ ent_raw[3][EW-1];
    unique case (pass_q)
      2'd0:    limb_last = LIMB_IW'(L0 - 1);
      2'd1:    limb_last = LIMB_IW'(L1 - 1);
      2'd2:    limb_last = LIMB_IW'(L2 - 1);
      default: limb_last = LIMB_IW'(NL - 1);
    endcase
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    n_d        = n_q;
    pass_d     = pass_q;
    limb_d     = limb_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    take_in    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          take_in = 1'b1;
          r_d     = VOIGT_FIRST_IDX;
          c_d     = VOIGT_FIRST_IDX;
          state_d = S_ENTRY;
        end
      end
      S_ENTRY: begin
        ctrl_o.init_acc = 1'b1;
        n_d             = FIRST_TERM;
        state_d         = S_LOAD;
      end
      S_LOAD: begin
        ctrl_o.load_term = 1'b1;
        ctrl_o.neg       = term_neg;
        pass_d           = PASS_FIRST;
        limb_d           = '0;
        state_d          = S_MUL;
      end
      S_MUL: begin
        ctrl_o.step      = 1'b1;
        ctrl_o.last_pass = (pass_q == PASS_LAST);
        if (limb_q == limb_last) begin
          limb_d = '0;
          if (pass_q == PASS_LAST) begin
            if (n_q == LAST_TERM) begin
              state_d = S_EMIT;
            end else begin
              n_d     = n_q + 1'b1;
              state_d = S_LOAD;
            end
          end else begin
            pass_d = pass_q + 2'd1;
          end
        end else begin
          limb_d = limb_q + 1'b1;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the entry
        if (out_free_i) begin
          out_load_o = 1'b1;
          if (c_q == VOIGT_LAST_IDX) begin
            c_d = VOIGT_FIRST_IDX;
            if (r_q == VOIGT_LAST_IDX) begin
              state_d = S_IDLE;
            end else begin
              r_d     = r_q + 1'b1;
              state_d = S_ENTRY;
            end
          end else begin
            c_d     = c_q + 1'b1;
            state_d = S_ENTRY;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign limb_o     = limb_q;
  assign out_row_o  = r_q;
  assign out_col_o  = c_q;
  assign out_last_o = (r_q == VOIGT_LAST_IDX) && (c_q == VOIGT_LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      n_q     <= '0;
      pass_q  <= '0;
      limb_q  <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      n_q     <= n_d;
      pass_q  <= pass_d;
      limb_q  <= limb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      for (int q = 0; q < 3; q++) begin
        mag_q[q]  <= in_mag[q];
        mneg_q[q] <= in_neg[q];
      end
    end
  end

endmodule

[hdl/cstr_checker.sv]
// Port-level checks of the cubic stiffness rotation block, bound to its top level.
module cstr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cstr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import cstr_pkg::*;

  logic [IDX_W-1:0] row, col;

  assign row = m_axis_tdata[IDX_W-1:0];
  assign col = m_axis_tdata[2*IDX_W-1:IDX_W];

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_last_is_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> row == VOIGT_LAST_IDX && col == VOIGT_LAST_IDX)
    else $error("tlast on an entry other than the last");

  a_corner_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && row == VOIGT_LAST_IDX && col == VOIGT_LAST_IDX |-> m_axis_tlast)
    else $error("last entry without tlast");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> row <= VOIGT_LAST_IDX && col <= VOIGT_LAST_IDX)
    else $error("Voigt index out of range");

  // a new input is refused straight after one has been taken
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a run is in progress");

endmodule

bind cubic_stiffness_rotation cstr_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
